### hw/rtl/grid_nearest_obstacle_search_unit_defines.svh
// assertion macros for the nearest obstacle search unit
// used by the top level only, no other dependencies
`ifndef GRID_NEAREST_OBSTACLE_SEARCH_UNIT_DEFINES_SVH
`define GRID_NEAREST_OBSTACLE_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GNOS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GNOS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gnos_pkg.sv
// shared types and constants of the nearest obstacle search unit
// no dependencies
package gnos_pkg;

    localparam int COLS_MAX   = 64;
    localparam int ROWS_MAX   = 64;
    localparam int RADIUS_MAX = 16;
    localparam int FRAC       = 8;

    localparam int COL_W   = 6;
    localparam int ROW_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int POS_W   = 16;
    localparam int SCALE_W = 16;
    localparam int DIST_W  = 13;
    localparam int CPOS_W  = 14;
    localparam int SQ_W    = 29;
    localparam int ROOT_W  = (SQ_W + 1) / 2;
    localparam int CNT_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 3'd4;

    localparam logic [DIST_W-1:0] RADIUS_CAP = DIST_W'(RADIUS_MAX << FRAC);

    typedef struct packed {
        logic [1:0]         action;
        logic [COL_W-1:0]   cell_col;
        logic [ROW_W-1:0]   cell_row;
        logic               cell_occupied;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic               found;
    } out_item_t;

    typedef struct packed {
        logic                 clr;
        logic                 rd_en;
        logic [ROW_W-1:0]     rd_addr;
        logic                 wr_en;
        logic [ROW_W-1:0]     wr_addr;
        logic [COLS_MAX-1:0]  wr_data;
    } mem_req_t;

    typedef struct packed {
        logic              vld;
        logic [CPOS_W-1:0] dy;
    } row_tag_t;

endpackage

### hw/rtl/gnos_row_mem.sv
// occupancy grid store, one grid row per entry, registered read with data in the cycle after the request
// row valid bits give the cleared state; uses gnos_pkg
module gnos_row_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gnos_pkg::mem_req_t            req,
    output logic [gnos_pkg::COLS_MAX-1:0] rd_data
);

    logic [gnos_pkg::COLS_MAX-1:0] mem [0:gnos_pkg::ROWS_MAX-1];
    logic [gnos_pkg::COLS_MAX-1:0] rd_q_reg;
    logic [gnos_pkg::ROWS_MAX-1:0] vld_reg;
    logic                          rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.clr) begin
                vld_reg <= '0;
            end else if (req.wr_en) begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    // a row never written since the last clear reads as free
    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

### hw/rtl/gnos_row_scan.sv
// per-row nearest cell pipeline: nearest occupied column, squares, running minimum
// uses gnos_pkg
module gnos_row_scan (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            init,
    input  logic [gnos_pkg::SQ_W-1:0]       init_best,
    input  logic [gnos_pkg::COLS_MAX-1:0]   col_mask,
    input  logic [gnos_pkg::CPOS_W-1:0]     px,
    input  logic [gnos_pkg::COLS_MAX-1:0]   row_bits,
    input  gnos_pkg::row_tag_t              tag,
    output logic [gnos_pkg::SQ_W-1:0]       best,
    output logic                            found,
    output logic                            busy
);

    logic [gnos_pkg::COLS_MAX-1:0] hits;
    logic [gnos_pkg::COL_W-1:0]    pcell;
    logic                          l_ok, r_ok;
    logic [gnos_pkg::COL_W-1:0]    l_idx, r_idx;

    logic                          s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic                          s1_l_reg, s1_r_reg;
    logic [gnos_pkg::COL_W-1:0]    s1_lidx_reg, s1_ridx_reg;
    logic [gnos_pkg::CPOS_W-1:0]   s1_dy_reg, s2_dy_reg;
    logic                          s2_hit_reg, s3_hit_reg;
    logic [gnos_pkg::CPOS_W-1:0]   s2_dx_reg;
    logic [2*gnos_pkg::CPOS_W-1:0] s3_dxsq_reg, s3_dysq_reg;
    logic [gnos_pkg::CPOS_W-1:0]   dx_l, dx_r, dx_sel;
    logic [gnos_pkg::SQ_W-1:0]     sum;
    logic [gnos_pkg::SQ_W-1:0]     best_reg;
    logic                          found_reg;

    assign hits  = row_bits & col_mask;
    assign pcell = px[gnos_pkg::CPOS_W-1:gnos_pkg::FRAC];

    // nearest occupied column at or left of the point, and right of it
    always_comb begin
        l_ok  = 1'b0;
        r_ok  = 1'b0;
        l_idx = '0;
        r_idx = '0;
        for (int i = 0; i < gnos_pkg::COLS_MAX; i++) begin
            if (hits[i] && gnos_pkg::COL_W'(i) <= pcell) begin
                l_ok  = 1'b1;
                l_idx = gnos_pkg::COL_W'(i);
            end
        end
        for (int i = gnos_pkg::COLS_MAX - 1; i >= 0; i--) begin
            if (hits[i] && gnos_pkg::COL_W'(i) > pcell) begin
                r_ok  = 1'b1;
                r_idx = gnos_pkg::COL_W'(i);
            end
        end
    end

    assign dx_l = px - {s1_lidx_reg, gnos_pkg::FRAC'(0)};
    assign dx_r = {s1_ridx_reg, gnos_pkg::FRAC'(0)} - px;

    always_comb begin
        if (s1_l_reg && s1_r_reg) begin
            dx_sel = (dx_l <= dx_r) ? dx_l : dx_r;
        end else if (s1_l_reg) begin
            dx_sel = dx_l;
        end else begin
            dx_sel = dx_r;
        end
    end

    assign sum = gnos_pkg::SQ_W'(s3_dxsq_reg) + gnos_pkg::SQ_W'(s3_dysq_reg);

    always_ff @(posedge aclk) begin
        s1_l_reg    <= l_ok;
        s1_r_reg    <= r_ok;
        s1_lidx_reg <= l_idx;
        s1_ridx_reg <= r_idx;
        s1_dy_reg   <= tag.dy;
        s2_hit_reg  <= s1_l_reg | s1_r_reg;
        s2_dx_reg   <= dx_sel;
        s2_dy_reg   <= s1_dy_reg;
        s3_hit_reg  <= s2_hit_reg;
        s3_dxsq_reg <= s2_dx_reg * s2_dx_reg;
        s3_dysq_reg <= s2_dy_reg * s2_dy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            best_reg   <= '0;
            found_reg  <= 1'b0;
        end else begin
            s1_vld_reg <= tag.vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            if (init) begin
                best_reg  <= init_best;
                found_reg <= 1'b0;
            end else if (s3_vld_reg && s3_hit_reg && sum < best_reg) begin
                best_reg  <= sum;
                found_reg <= 1'b1;
            end
        end
    end

    assign best  = best_reg;
    assign found = found_reg;
    assign busy  = s1_vld_reg | s2_vld_reg | s3_vld_reg;

endmodule

### hw/rtl/gnos_isqrt.sv
// floor square root, digit recurrence, one root bit per cycle
// uses gnos_pkg
module gnos_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [gnos_pkg::SQ_W-1:0]     value,
    output logic                          done,
    output logic [gnos_pkg::ROOT_W-1:0]   root
);

    localparam int VW = 2 * gnos_pkg::ROOT_W;
    localparam int RW = gnos_pkg::ROOT_W + 1;

    logic [VW-1:0]                 v_reg;
    logic [RW-1:0]                 rem_reg;
    logic [gnos_pkg::ROOT_W-1:0]   root_reg;
    logic [gnos_pkg::CNT_W-1:0]    cnt_reg;
    logic                          busy_reg, done_reg;
    logic [RW+1:0]                 remx, trial;

    assign remx  = {rem_reg, v_reg[VW-1:VW-2]};
    assign trial = (RW+2)'({root_reg, 2'b01});

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg    <= VW'(value);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            v_reg <= {v_reg[VW-3:0], 2'b00};
            if (remx >= trial) begin
                rem_reg  <= RW'(remx - trial);
                root_reg <= {root_reg[gnos_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= RW'(remx);
                root_reg <= {root_reg[gnos_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == gnos_pkg::CNT_W'(gnos_pkg::ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### hw/rtl/grid_nearest_obstacle_search_unit.sv
// nearest obstacle search on a 64 x 64 one-bit occupancy grid
// clear on accept; a cell write reads its row and writes it back (skipped outside grid)
//   query: scale, window, up to 33 rows read, drain, root if found; one request at a time
// throughput set by one grid row read per cycle from the row store, then the root unit
// reset: synchronous active-low aresetn, grid all free, control and config registers to defaults
// depends on gnos_pkg, gnos_row_mem, gnos_row_scan, gnos_isqrt and the defines header
`include "grid_nearest_obstacle_search_unit_defines.svh"

module grid_nearest_obstacle_search_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  gnos_pkg::in_item_t                 s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output gnos_pkg::out_item_t                m_item,
    input  logic                               cfg_we,
    input  logic [gnos_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gnos_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_WR_RD = 10'b0000000010,
        ST_WR_WR = 10'b0000000100,
        ST_Q_MUL = 10'b0000001000,
        ST_Q_SCL = 10'b0000010000,
        ST_Q_WIN = 10'b0000100000,
        ST_Q_ROW = 10'b0001000000,
        ST_Q_DRN = 10'b0010000000,
        ST_Q_SQR = 10'b0100000000,
        ST_Q_OUT = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [gnos_pkg::SIZE_W-1:0]  cols_cfg_reg, rows_cfg_reg;
    logic [gnos_pkg::SCALE_W-1:0] cpu_x_reg, cpu_y_reg;
    logic [gnos_pkg::DIST_W-1:0]  max_dist_reg;

    // captured request
    gnos_pkg::in_item_t           req_reg;

    // query datapath
    logic [2*gnos_pkg::POS_W-1:0] prod_x_reg, prod_y_reg;
    logic [gnos_pkg::CPOS_W-1:0]  px_reg, py_reg;
    logic [gnos_pkg::COLS_MAX-1:0] mask_reg;
    logic [gnos_pkg::SIZE_W-1:0]  j_reg, jlim_reg;
    gnos_pkg::row_tag_t           tag_reg;

    // result
    logic [gnos_pkg::DIST_W-1:0]  res_dist_reg;
    logic                         res_found_reg;
    gnos_pkg::out_item_t          out_reg;
    logic                         out_vld_reg;

    logic [gnos_pkg::SIZE_W-1:0]  cols, rows;
    logic [gnos_pkg::DIST_W-1:0]  c_rad;
    logic [gnos_pkg::CPOS_W:0]    top_x, top_y;
    logic [gnos_pkg::CPOS_W-1:0]  px_sat, py_sat;
    logic [gnos_pkg::COL_W-1:0]   i0;
    logic [gnos_pkg::ROW_W-1:0]   j0;
    logic [gnos_pkg::CPOS_W:0]    ihi_sum, jhi_sum;
    logic [gnos_pkg::SIZE_W-1:0]  ilim, jlim;
    logic [gnos_pkg::COLS_MAX-1:0] mask_next;
    logic [gnos_pkg::CPOS_W-1:0]  row_pos, dy;
    logic                         row_issue;
    logic                         wr_in_grid;

    gnos_pkg::mem_req_t           mem_req;
    logic [gnos_pkg::COLS_MAX-1:0] row_data;
    logic                         scan_init, scan_found, scan_busy;
    logic [gnos_pkg::SQ_W-1:0]    scan_best;
    logic                         sqrt_start, sqrt_done;
    logic [gnos_pkg::ROOT_W-1:0]  sqrt_root;
    logic                         drained, out_free, s_acc;

    // grid size in use: zero reads as one, larger values saturate
    assign cols = (cols_cfg_reg == '0) ? gnos_pkg::SIZE_W'(1) :
                  (cols_cfg_reg > gnos_pkg::SIZE_W'(gnos_pkg::COLS_MAX)) ?
                  gnos_pkg::SIZE_W'(gnos_pkg::COLS_MAX) : cols_cfg_reg;
    assign rows = (rows_cfg_reg == '0) ? gnos_pkg::SIZE_W'(1) :
                  (rows_cfg_reg > gnos_pkg::SIZE_W'(gnos_pkg::ROWS_MAX)) ?
                  gnos_pkg::SIZE_W'(gnos_pkg::ROWS_MAX) : rows_cfg_reg;

    // search radius saturated at the largest window
    assign c_rad = (max_dist_reg > gnos_pkg::RADIUS_CAP) ? gnos_pkg::RADIUS_CAP : max_dist_reg;

    // scaled position saturated to the last fractional point inside the grid
    assign top_x  = {cols, gnos_pkg::FRAC'(0)} - 1'b1;
    assign top_y  = {rows, gnos_pkg::FRAC'(0)} - 1'b1;
    assign px_sat = (prod_x_reg[2*gnos_pkg::POS_W-1:gnos_pkg::FRAC] > 24'(top_x)) ?
                    top_x[gnos_pkg::CPOS_W-1:0] :
                    prod_x_reg[gnos_pkg::CPOS_W+gnos_pkg::FRAC-1:gnos_pkg::FRAC];
    assign py_sat = (prod_y_reg[2*gnos_pkg::POS_W-1:gnos_pkg::FRAC] > 24'(top_y)) ?
                    top_y[gnos_pkg::CPOS_W-1:0] :
                    prod_y_reg[gnos_pkg::CPOS_W+gnos_pkg::FRAC-1:gnos_pkg::FRAC];

    // window bounds: first cell at floor(p - c), last cell below p + c
    always_comb begin
        logic [gnos_pkg::CPOS_W-1:0] dlo_x, dlo_y;
        dlo_x = px_reg - gnos_pkg::CPOS_W'(c_rad);
        dlo_y = py_reg - gnos_pkg::CPOS_W'(c_rad);
        i0 = (px_reg >= gnos_pkg::CPOS_W'(c_rad)) ?
             dlo_x[gnos_pkg::CPOS_W-1:gnos_pkg::FRAC] : '0;
        j0 = (py_reg >= gnos_pkg::CPOS_W'(c_rad)) ?
             dlo_y[gnos_pkg::CPOS_W-1:gnos_pkg::FRAC] : '0;
        ihi_sum = (gnos_pkg::CPOS_W+1)'(px_reg) + (gnos_pkg::CPOS_W+1)'(c_rad)
                  + (gnos_pkg::CPOS_W+1)'(255);
        jhi_sum = (gnos_pkg::CPOS_W+1)'(py_reg) + (gnos_pkg::CPOS_W+1)'(c_rad)
                  + (gnos_pkg::CPOS_W+1)'(255);
        ilim = (ihi_sum[gnos_pkg::CPOS_W:gnos_pkg::FRAC] < cols) ?
               ihi_sum[gnos_pkg::CPOS_W:gnos_pkg::FRAC] : cols;
        jlim = (jhi_sum[gnos_pkg::CPOS_W:gnos_pkg::FRAC] < rows) ?
               jhi_sum[gnos_pkg::CPOS_W:gnos_pkg::FRAC] : rows;
        for (int i = 0; i < gnos_pkg::COLS_MAX; i++) begin
            mask_next[i] = (gnos_pkg::SIZE_W'(i) >= {1'b0, i0}) &&
                           (gnos_pkg::SIZE_W'(i) < ilim);
        end
    end

    // row issue and its vertical offset
    assign row_issue = (state_reg == ST_Q_ROW) && (j_reg < jlim_reg);
    assign row_pos   = {j_reg[gnos_pkg::ROW_W-1:0], gnos_pkg::FRAC'(0)};
    assign dy        = (py_reg >= row_pos) ? (py_reg - row_pos) : (row_pos - py_reg);

    assign wr_in_grid = (gnos_pkg::SIZE_W'(req_reg.cell_col) < cols) &&
                        (gnos_pkg::SIZE_W'(req_reg.cell_row) < rows);

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !out_vld_reg || m_ready;
    assign drained  = !tag_reg.vld && !scan_busy;

    // store requests: clear on accept, read-modify-write for a cell, row reads for a query
    always_comb begin
        mem_req         = '0;
        mem_req.clr     = s_acc && (s_item.action == gnos_pkg::ACT_CLEAR);
        mem_req.wr_addr = req_reg.cell_row;
        mem_req.wr_data = (row_data & ~(gnos_pkg::COLS_MAX'(1) << req_reg.cell_col)) |
                          (gnos_pkg::COLS_MAX'(req_reg.cell_occupied) << req_reg.cell_col);
        if (state_reg == ST_WR_RD) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = req_reg.cell_row;
        end else begin
            mem_req.rd_en   = row_issue;
            mem_req.rd_addr = j_reg[gnos_pkg::ROW_W-1:0];
        end
        mem_req.wr_en = (state_reg == ST_WR_WR);
    end

    assign scan_init  = (state_reg == ST_Q_WIN);
    assign sqrt_start = (state_reg == ST_Q_DRN) && drained && scan_found;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_item.action)
                        gnos_pkg::ACT_WRITE: state_next = ST_WR_RD;
                        gnos_pkg::ACT_QUERY: state_next = ST_Q_MUL;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WR_RD: state_next = wr_in_grid ? ST_WR_WR : ST_IDLE;
            ST_WR_WR: state_next = ST_IDLE;
            ST_Q_MUL: state_next = ST_Q_SCL;
            ST_Q_SCL: state_next = ST_Q_WIN;
            ST_Q_WIN: state_next = ST_Q_ROW;
            ST_Q_ROW: begin
                if (!row_issue) begin
                    state_next = ST_Q_DRN;
                end
            end
            ST_Q_DRN: begin
                if (drained) begin
                    state_next = scan_found ? ST_Q_SQR : ST_Q_OUT;
                end
            end
            ST_Q_SQR: begin
                if (sqrt_done) begin
                    state_next = ST_Q_OUT;
                end
            end
            ST_Q_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            req_reg <= s_item;
        end
        if (state_reg == ST_Q_MUL) begin
            prod_x_reg <= (2*gnos_pkg::POS_W)'(req_reg.pos_x) * (2*gnos_pkg::POS_W)'(cpu_x_reg);
            prod_y_reg <= (2*gnos_pkg::POS_W)'(req_reg.pos_y) * (2*gnos_pkg::POS_W)'(cpu_y_reg);
        end
        if (state_reg == ST_Q_SCL) begin
            px_reg <= px_sat;
            py_reg <= py_sat;
        end
        if (state_reg == ST_Q_WIN) begin
            mask_reg <= mask_next;
            jlim_reg <= jlim;
        end
        if (state_reg == ST_Q_DRN && drained && !scan_found) begin
            res_dist_reg  <= max_dist_reg;
            res_found_reg <= 1'b0;
        end else if (sqrt_done) begin
            res_dist_reg  <= sqrt_root[gnos_pkg::DIST_W-1:0];
            res_found_reg <= 1'b1;
        end
        if (state_reg == ST_Q_OUT && out_free) begin
            out_reg.distance <= res_dist_reg;
            out_reg.found    <= res_found_reg;
        end
    end

    // control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tag_reg      <= '0;
            j_reg        <= '0;
            out_vld_reg  <= 1'b0;
            cols_cfg_reg <= gnos_pkg::SIZE_W'(gnos_pkg::COLS_MAX);
            rows_cfg_reg <= gnos_pkg::SIZE_W'(gnos_pkg::ROWS_MAX);
            cpu_x_reg    <= gnos_pkg::SCALE_W'(1 << gnos_pkg::FRAC);
            cpu_y_reg    <= gnos_pkg::SCALE_W'(1 << gnos_pkg::FRAC);
            max_dist_reg <= gnos_pkg::DIST_W'(5 << gnos_pkg::FRAC);
        end else begin
            state_reg   <= state_next;
            tag_reg.vld <= row_issue;
            tag_reg.dy  <= dy;
            if (state_reg == ST_Q_WIN) begin
                j_reg <= {1'b0, j0};
            end else if (row_issue) begin
                j_reg <= j_reg + 1'b1;
            end
            if (state_reg == ST_Q_OUT && out_free) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    gnos_pkg::REG_GRID_COLS: cols_cfg_reg <= cfg_wdata[gnos_pkg::SIZE_W-1:0];
                    gnos_pkg::REG_GRID_ROWS: rows_cfg_reg <= cfg_wdata[gnos_pkg::SIZE_W-1:0];
                    gnos_pkg::REG_CPU_X:     cpu_x_reg    <= cfg_wdata;
                    gnos_pkg::REG_CPU_Y:     cpu_y_reg    <= cfg_wdata;
                    gnos_pkg::REG_MAX_DIST:  max_dist_reg <= cfg_wdata[gnos_pkg::DIST_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_valid = out_vld_reg;
    assign m_item  = out_reg;

    gnos_row_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (row_data)
    );

    gnos_row_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init      (scan_init),
        .init_best (gnos_pkg::SQ_W'(c_rad) * gnos_pkg::SQ_W'(c_rad)),
        .col_mask  (mask_reg),
        .px        (px_reg),
        .row_bits  (row_data),
        .tag       (tag_reg),
        .best      (scan_best),
        .found     (scan_found),
        .busy      (scan_busy)
    );

    gnos_isqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .value   (scan_best),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // no request taken while rows are still in the scan pipeline
    `GNOS_ASSERT_IMPL(a_idle_drained, aclk, aresetn, s_ready, !scan_busy && !tag_reg.vld, "request accepted with scan in flight")
    // the row store is never written during a window scan
    `GNOS_ASSERT_IMPL(a_no_wr_in_scan, aclk, aresetn, state_reg == ST_Q_ROW || state_reg == ST_Q_DRN, !mem_req.wr_en, "row store written during scan")
    // a found obstacle lies strictly inside the radius
    `GNOS_ASSERT_IMPL(a_found_inside, aclk, aresetn, m_valid && m_item.found, m_item.distance < max_dist_reg, "found distance not below radius")
    // a result load never overwrites one still waiting
    `GNOS_ASSERT_NEXT(a_out_load, aclk, aresetn, state_reg == ST_Q_OUT && out_free, m_valid, "result lost on load")

endmodule
